// File: hdl/trsu_pkg.sv
// Shared types, codes and helpers for the two-relay fire sequencer.
// Used by trsu_cfg, trsu_core and the top level two_relay_fire_sequencer_unit.
`default_nettype none

package trsu_pkg;

  localparam int DurW  = 16;
  localparam int CfgAW = 3;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  // Refusal reasons.
  localparam logic [1:0] REFUSE_NONE   = 2'd0;
  localparam logic [1:0] REFUSE_FIRING = 2'd1;
  localparam logic [1:0] REFUSE_COOL   = 2'd2;

  // Reported phase codes.
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_PREFIRE = 2'd1;
  localparam logic [1:0] PHASE_WAIT1   = 2'd2;
  localparam logic [1:0] PHASE_WAIT2   = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgAW-1:0] REG_PREFIRE  = 3'd0;
  localparam logic [CfgAW-1:0] REG_CHANNEL  = 3'd1;
  localparam logic [CfgAW-1:0] REG_MIN_DUR  = 3'd2;
  localparam logic [CfgAW-1:0] REG_MAX_DUR  = 3'd3;
  localparam logic [CfgAW-1:0] REG_COOLDOWN = 3'd4;
  localparam logic [CfgAW-1:0] REG_TWO_CH   = 3'd5;

  localparam logic [DurW-1:0] MIN_DUR_RESET = 16'd100;
  localparam logic [DurW-1:0] MAX_DUR_RESET = 16'd5000;
  localparam logic [DurW-1:0] ELAPSED_MAX   = 16'hFFFF;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_PREFIRE = 4'b0010,
    PH_WAIT1   = 4'b0100,
    PH_WAIT2   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [DurW-1:0] pre_delay;
    logic [DurW-1:0] channel_delay;
    logic [DurW-1:0] min_duration;
    logic [DurW-1:0] max_duration;
    logic [DurW-1:0] cooldown;
    logic            two_channels;
  } cfg_t;

  // Field order gives the tdata packing, relay_one_on in bit 0.
  typedef struct packed {
    logic       cooldown_active;
    logic       sequence_done;
    logic [1:0] refuse_reason;
    logic       start_accepted;
    logic [1:0] phase;
    logic       relay_two_on;
    logic       relay_one_on;
  } result_t;

  function automatic logic [1:0] phase_code(phase_t ph);
    logic [1:0] code;
    code = PHASE_IDLE;
    unique case (ph)
      PH_IDLE:    code = PHASE_IDLE;
      PH_PREFIRE: code = PHASE_PREFIRE;
      PH_WAIT1:   code = PHASE_WAIT1;
      PH_WAIT2:   code = PHASE_WAIT2;
      default:    code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// File: hdl/trsu_cfg.sv
// Configuration register file of the fire sequencer.
// Depends on trsu_pkg for the register indexes and the cfg_t bundle.
`default_nettype none

module trsu_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [trsu_pkg::CfgAW-1:0] cfg_addr,
  input  wire logic [trsu_pkg::DurW-1:0]  cfg_wdata,
  output trsu_pkg::cfg_t                  cfg
);
  import trsu_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_delay     <= '0;
      cfg_r.channel_delay <= '0;
      cfg_r.min_duration  <= MIN_DUR_RESET;
      cfg_r.max_duration  <= MAX_DUR_RESET;
      cfg_r.cooldown      <= '0;
      cfg_r.two_channels  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PREFIRE:  cfg_r.pre_delay     <= cfg_wdata;
        REG_CHANNEL:  cfg_r.channel_delay <= cfg_wdata;
        REG_MIN_DUR:  cfg_r.min_duration  <= cfg_wdata;
        REG_MAX_DUR:  cfg_r.max_duration  <= cfg_wdata;
        REG_COOLDOWN: cfg_r.cooldown      <= cfg_wdata;
        REG_TWO_CH:   cfg_r.two_channels  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// File: hdl/trsu_core.sv
// Sequencer state and its single-pass update for one item.
// Depends on trsu_pkg; the result is combinational and registered by the top level.
`default_nettype none

module trsu_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [1:0]                mode,
  input  wire logic [trsu_pkg::DurW-1:0] fire_len,
  input  wire trsu_pkg::cfg_t            cfg,
  output trsu_pkg::result_t              result
);
  import trsu_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [DurW-1:0] elapsed_r, elapsed_nxt;
  logic [DurW-1:0] active_dur_r, active_dur_nxt;
  logic [DurW-1:0] cool_r, cool_nxt;
  logic            relay1_r, relay1_nxt;
  logic            relay2_r, relay2_nxt;
  logic [DurW-1:0] elapsed_inc;
  logic [DurW-1:0] clamped;
  logic            accepted;
  logic            done;
  logic [1:0]      refuse;

  always_comb begin
    // Sequence time saturates rather than wrapping.
    elapsed_inc = elapsed_r;
    if (phase_r != PH_IDLE && elapsed_r != ELAPSED_MAX) begin
      elapsed_inc = elapsed_r + 16'd1;
    end

    clamped = fire_len;
    if (fire_len < cfg.min_duration) begin
      clamped = cfg.min_duration;
    end else if (fire_len > cfg.max_duration) begin
      clamped = cfg.max_duration;
    end
  end

  always_comb begin
    phase_nxt      = phase_r;
    elapsed_nxt    = elapsed_r;
    active_dur_nxt = active_dur_r;
    cool_nxt       = cool_r;
    relay1_nxt     = relay1_r;
    relay2_nxt     = relay2_r;
    accepted       = 1'b0;
    done           = 1'b0;
    refuse         = REFUSE_NONE;

    case (mode)
      MODE_TICK: begin
        cool_nxt    = (cool_r != '0) ? cool_r - 16'd1 : cool_r;
        elapsed_nxt = elapsed_inc;
        unique case (phase_r)
          PH_PREFIRE: begin
            if (elapsed_inc >= cfg.pre_delay) begin
              relay1_nxt  = 1'b1;
              relay2_nxt  = 1'b0;
              phase_nxt   = PH_WAIT1;
              elapsed_nxt = '0;
            end
          end
          PH_WAIT1: begin
            if (cfg.two_channels) begin
              if (elapsed_inc >= cfg.channel_delay) begin
                relay2_nxt  = 1'b1;
                phase_nxt   = PH_WAIT2;
                elapsed_nxt = '0;
              end
            end else if (elapsed_inc >= active_dur_r) begin
              relay1_nxt  = 1'b0;
              relay2_nxt  = 1'b0;
              phase_nxt   = PH_IDLE;
              elapsed_nxt = '0;
              cool_nxt    = cfg.cooldown;
              done        = 1'b1;
            end
          end
          PH_WAIT2: begin
            if (elapsed_inc >= active_dur_r) begin
              relay1_nxt  = 1'b0;
              relay2_nxt  = 1'b0;
              phase_nxt   = PH_IDLE;
              elapsed_nxt = '0;
              cool_nxt    = cfg.cooldown;
              done        = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_START: begin
        if (phase_r != PH_IDLE) begin
          refuse = REFUSE_FIRING;
        end else if (cool_r != '0) begin
          refuse = REFUSE_COOL;
        end else begin
          active_dur_nxt = clamped;
          phase_nxt      = PH_PREFIRE;
          elapsed_nxt    = '0;
          accepted       = 1'b1;
        end
      end
      MODE_STOP: begin
        relay1_nxt = 1'b0;
        relay2_nxt = 1'b0;
        if (phase_r != PH_IDLE) begin
          phase_nxt   = PH_IDLE;
          elapsed_nxt = '0;
          cool_nxt    = cfg.cooldown;
          done        = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      elapsed_r    <= '0;
      active_dur_r <= '0;
      cool_r       <= '0;
      relay1_r     <= 1'b0;
      relay2_r     <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      elapsed_r    <= elapsed_nxt;
      active_dur_r <= active_dur_nxt;
      cool_r       <= cool_nxt;
      relay1_r     <= relay1_nxt;
      relay2_r     <= relay2_nxt;
    end
  end

  always_comb begin
    result.relay_one_on    = relay1_nxt;
    result.relay_two_on    = relay2_nxt;
    result.phase           = phase_code(phase_nxt);
    result.start_accepted  = accepted;
    result.refuse_reason   = refuse;
    result.sequence_done   = done;
    result.cooldown_active = (cool_nxt != '0);
  end

endmodule

`default_nettype wire

// File: hdl/two_relay_fire_sequencer_unit.sv
// Two-relay fire sequencer: configuration registers, item register, state update, result register.
// Depends on trsu_pkg, trsu_cfg and trsu_core.
`default_nettype none

// Each input item (a tick, a start or a stop) produces exactly one result item that
// reports the relay drives, the phase and the start/stop outcome after that item.
// The block takes one item per clock cycle unless the result stalls; each item passes
// from the input item register through the combinational state update into the result
// register. A stalled result holds the input side only once the item register is also
// full. Configuration is written through cfg_we/cfg_addr, by the user only while no item
// is in flight (not enforced by the block); writes to indexes beyond the list are ignored.
module two_relay_fire_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] requested fire length
  input  wire logic [1:0]  in_tuser,   // [1:0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [0] relay_one_on, [1] relay_two_on, [3:2] phase, [4] start_accepted,
  // [6:5] refuse_reason, [7] sequence_done, [8] cooldown_active, [15:9] zero
  output logic [15:0]      out_tdata,
  input  wire logic        cfg_we,
  input  wire logic [trsu_pkg::CfgAW-1:0] cfg_addr,
  input  wire logic [trsu_pkg::DurW-1:0]  cfg_wdata
);
  import trsu_pkg::*;

  cfg_t            cfg;
  result_t         result;
  result_t         out_res_r;
  logic            out_valid_r;
  logic            in_valid_r;
  logic [1:0]      in_mode_r;
  logic [DurW-1:0] in_dur_r;
  logic            advance;
  logic            step;

  trsu_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  trsu_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .mode     (in_mode_r),
    .fire_len (in_dur_r),
    .cfg      (cfg),
    .result   (result)
  );

  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser;
      in_dur_r  <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r};

  // Relay one is driven exactly while the sequence sits in a relay wait phase.
  a_relay_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.relay_one_on ==
      (out_res_r.phase == PHASE_WAIT1 || out_res_r.phase == PHASE_WAIT2)))
    else $error("relay one drive disagrees with phase");

  // Relay two only ever runs together with relay one in the last phase.
  a_relay_two_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.relay_two_on) |->
      (out_res_r.relay_one_on && out_res_r.phase == PHASE_WAIT2))
    else $error("relay two on outside the second wait phase");

  // An accepted start always lands in prefire and is never also refused.
  a_start_prefire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.start_accepted) |->
      (out_res_r.phase == PHASE_PREFIRE && out_res_r.refuse_reason == REFUSE_NONE))
    else $error("accepted start not in prefire");

  // A finished or stopped sequence leaves the block idle with both relays off.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.sequence_done) |->
      (out_res_r.phase == PHASE_IDLE && !out_res_r.relay_one_on &&
       !out_res_r.relay_two_on))
    else $error("sequence done while not idle");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for two_relay_fire_sequencer_unit: directed and random
// tick, start and stop items checked against a cycle-free predictor of the sequencer.
// Depends on trsu_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_top;
  import trsu_pkg::*;

  localparam logic [1:0]       MODE_UNUSED = 2'd3;
  localparam logic [CfgAW-1:0] REG_UNUSED  = 3'd6;
  localparam int               CYCLE_LIMIT = 400000;
  localparam int               RAND_PHASES = 6;
  localparam int               PHASE_ITEMS = 90;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [15:0]      in_tdata = '0;   // [15:0] requested fire length
  logic [1:0]       in_tuser = '0;   // [1:0] mode
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  // [0] relay_one_on, [1] relay_two_on, [3:2] phase, [4] start_accepted,
  // [6:5] refuse_reason, [7] sequence_done, [8] cooldown_active
  logic [15:0]      out_tdata;
  logic             cfg_we = 1'b0;
  logic [CfgAW-1:0] cfg_addr = '0;
  logic [DurW-1:0]  cfg_wdata = '0;

  logic quiet = 1'b0;
  int   fail_count = 0;

  // Predicted sequencer state and register copies.
  logic [1:0]      seq_phase;
  logic [DurW-1:0] seq_elapsed;
  logic [DurW-1:0] seq_duration;
  logic [DurW-1:0] cool_left;
  logic            relay_one;
  logic            relay_two;
  logic [DurW-1:0] prefire_ticks;
  logic [DurW-1:0] channel_ticks;
  logic [DurW-1:0] min_ticks;
  logic [DurW-1:0] max_ticks;
  logic [DurW-1:0] cooldown_ticks;
  logic            two_channel_mode;

  result_t pending_status[$];
  result_t want;
  result_t got;

  two_relay_fire_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  always @(posedge clk) begin
    out_tready <= quiet || ($urandom_range(99) >= 9);
  end

  task automatic end_sequence();
    relay_one   = 1'b0;
    relay_two   = 1'b0;
    seq_phase   = PHASE_IDLE;
    seq_elapsed = '0;
    cool_left   = cooldown_ticks;
  endtask

  task automatic advance_sequencer(input logic [1:0] mode, input logic [DurW-1:0] req);
    result_t r;
    r = '0;
    case (mode)
      MODE_TICK: begin
        if (cool_left != 0) cool_left = cool_left - 1'b1;
        if (seq_phase != PHASE_IDLE && seq_elapsed != ELAPSED_MAX)
          seq_elapsed = seq_elapsed + 1'b1;
        case (seq_phase)
          PHASE_PREFIRE: begin
            if (seq_elapsed >= prefire_ticks) begin
              relay_one   = 1'b1;
              relay_two   = 1'b0;
              seq_phase   = PHASE_WAIT1;
              seq_elapsed = '0;
            end
          end
          PHASE_WAIT1: begin
            // The channel mode is looked at afresh on every tick of this phase.
            if (two_channel_mode) begin
              if (seq_elapsed >= channel_ticks) begin
                relay_two   = 1'b1;
                seq_phase   = PHASE_WAIT2;
                seq_elapsed = '0;
              end
            end else if (seq_elapsed >= seq_duration) begin
              end_sequence();
              r.sequence_done = 1'b1;
            end
          end
          PHASE_WAIT2: begin
            if (seq_elapsed >= seq_duration) begin
              end_sequence();
              r.sequence_done = 1'b1;
            end
          end
          default: ;
        endcase
      end
      MODE_START: begin
        if (seq_phase != PHASE_IDLE) begin
          r.refuse_reason = REFUSE_FIRING;
        end else if (cool_left != 0) begin
          r.refuse_reason = REFUSE_COOL;
        end else begin
          // With min above max, a request below min still gets min.
          if (req < min_ticks) seq_duration = min_ticks;
          else if (req > max_ticks) seq_duration = max_ticks;
          else seq_duration = req;
          seq_phase        = PHASE_PREFIRE;
          seq_elapsed      = '0;
          r.start_accepted = 1'b1;
        end
      end
      MODE_STOP: begin
        if (seq_phase != PHASE_IDLE) begin
          end_sequence();
          r.sequence_done = 1'b1;
        end else begin
          relay_one = 1'b0;
          relay_two = 1'b0;
        end
      end
      default: ;
    endcase
    r.relay_one_on    = relay_one;
    r.relay_two_on    = relay_two;
    r.phase           = seq_phase;
    r.cooldown_active = (cool_left != 0);
    pending_status.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [6:0] exp_v, input logic [6:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // Everything settles between clock edges, so the handshakes are read at the falling edge.
  always @(negedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_status.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
      end else begin
        want = pending_status.pop_front();
        got  = result_t'(out_tdata[$bits(result_t)-1:0]);
        check_field("relay_one_on", want.relay_one_on, got.relay_one_on);
        check_field("relay_two_on", want.relay_two_on, got.relay_two_on);
        check_field("phase", want.phase, got.phase);
        check_field("start_accepted", want.start_accepted, got.start_accepted);
        check_field("refuse_reason", want.refuse_reason, got.refuse_reason);
        check_field("sequence_done", want.sequence_done, got.sequence_done);
        check_field("cooldown_active", want.cooldown_active, got.cooldown_active);
        check_field("padding", '0, out_tdata[15:$bits(result_t)]);
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [DurW-1:0] req);
    while (!quiet && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= req;
    do @(negedge clk); while (in_tready !== 1'b1);
    advance_sequencer(mode, req);
    @(posedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(MODE_TICK, 16'($urandom));
  endtask

  // Holds off the sender until every result is back and the pipeline is empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgAW-1:0] idx, input logic [DurW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PREFIRE:  prefire_ticks    = val;
      REG_CHANNEL:  channel_ticks    = val;
      REG_MIN_DUR:  min_ticks        = val;
      REG_MAX_DUR:  max_ticks        = val;
      REG_COOLDOWN: cooldown_ticks   = val;
      REG_TWO_CH:   two_channel_mode = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [DurW-1:0] prefire, input logic [DurW-1:0] chan,
                               input logic [DurW-1:0] mn, input logic [DurW-1:0] mx,
                               input logic [DurW-1:0] cool, input logic two);
    settle();
    write_reg(REG_PREFIRE, prefire);
    write_reg(REG_CHANNEL, chan);
    write_reg(REG_MIN_DUR, mn);
    write_reg(REG_MAX_DUR, mx);
    write_reg(REG_COOLDOWN, cool);
    // Upper bits of the mode register are don't-care.
    write_reg(REG_TWO_CH, {15'($urandom), two});
  endtask

  task automatic test_reset_defaults();
    send_item(MODE_TICK, 16'h0000);
    send_item(MODE_STOP, 16'hFFFF);        // stop while idle reports no completion
    send_item(MODE_UNUSED, 16'hA5A5);
    send_item(MODE_START, 16'h0000);       // clamped up to the reset minimum
    send_item(MODE_START, 16'hFFFF);       // refused, already firing
    send_item(MODE_STOP, 16'h0000);
    send_item(MODE_START, 16'hFFFF);       // clamped down to the reset maximum
    send_ticks(2);                         // zero prefire: relay one on at the first tick
    send_item(MODE_STOP, 16'h5A5A);
  endtask

  task automatic test_two_channel_sequence();
    load_settings(16'd2, 16'd1, 16'd3, 16'd5, 16'd3, 1'b1);
    send_item(MODE_START, 16'd0);
    send_ticks(6);                         // prefire, relay two, then the duration
    send_item(MODE_START, 16'd4);          // refused, cooling down
    send_ticks(3);
    send_item(MODE_START, 16'd9);
    send_item(MODE_STOP, 16'd0);
  endtask

  task automatic test_clamp_min_above_max();
    load_settings(16'd0, 16'd0, 16'd10, 16'd2, 16'd0, 1'b0);
    send_ticks(3);
    send_item(MODE_START, 16'd1);          // below min gives min
    send_item(MODE_STOP, 16'd0);
    send_item(MODE_START, 16'd5);          // otherwise max
    send_ticks(4);
  endtask

  task automatic test_channel_switch_mid_sequence();
    load_settings(16'd0, 16'd3, 16'd4, 16'd4, 16'd0, 1'b1);
    send_item(MODE_START, 16'd4);
    send_ticks(2);
    settle();
    // Dropping to one channel while waiting for relay two ends the wait on the duration.
    write_reg(REG_TWO_CH, 16'd0);
    send_ticks(4);
  endtask

  task automatic test_extreme_settings();
    load_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'd48, 1'b1);
    write_reg(REG_UNUSED, 16'h1234);       // out-of-range index must be ignored
    send_item(MODE_START, 16'hFFFF);
    send_ticks(2);
    send_item(MODE_STOP, 16'h0000);
    send_item(MODE_START, 16'h0001);       // refused, still cooling down
    quiet <= 1'b1;
    send_ticks(48);
    quiet <= 1'b0;
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_item(MODE_START, 16'h0000);       // zero duration ends right after relay one on
    send_ticks(2);
  endtask

  task automatic test_random_traffic();
    int         count;
    int         pick;
    logic [1:0] mode;
    logic [DurW-1:0] req;
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_settings(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                    16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)),
                    16'($urandom_range(0, 6)), 1'($urandom_range(0, 1)));
      quiet <= (p == 3);
      count = 0;
      while (count < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 72) mode = MODE_TICK;
        else if (pick < 84) mode = MODE_START;
        else if (pick < 92) mode = MODE_STOP;
        else mode = MODE_UNUSED;
        req = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 10));
        send_item(mode, req);
        if (mode != MODE_UNUSED) count++;
        if (count == PHASE_ITEMS / 2 && mode != MODE_UNUSED) settle();
      end
    end
    quiet <= 1'b0;
  endtask

  initial begin
    seq_phase        = PHASE_IDLE;
    seq_elapsed      = '0;
    seq_duration     = '0;
    cool_left        = '0;
    relay_one        = 1'b0;
    relay_two        = 1'b0;
    prefire_ticks    = '0;
    channel_ticks    = '0;
    min_ticks        = MIN_DUR_RESET;
    max_ticks        = MAX_DUR_RESET;
    cooldown_ticks   = '0;
    two_channel_mode = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_two_channel_sequence();
    test_clamp_min_above_max();
    test_channel_switch_mid_sequence();
    test_extreme_settings();
    test_random_traffic();
    settle();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
